// ===== sv/lgs_pkg.sv =====
// Shared definitions for the life generation step unit: grid geometry,
// request codes, controller states and the cell control word. No dependencies.
package lgs_pkg;

   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 64;
   localparam int LIFE_CELLS  = GRID_WIDTH * GRID_HEIGHT;

   // sweep counter covers one pass over the grid
   localparam int CNT_W = (LIFE_CELLS > 1) ? $clog2(LIFE_CELLS) : 1;
   localparam int IDX_W = 12;
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   localparam int NBR_W     = 8;
   localparam int NBR_CNT_W = 4;

   localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT = NBR_CNT_W'(3);
   localparam logic [NBR_CNT_W-1:0] KEEP_COUNT  = NBR_CNT_W'(2);

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_STEP  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_COMMIT,
      ST_FINISH
   } lgs_state_type;

   typedef struct packed {
      logic shift;
      logic commit;
   } cell_ctl_type;

endpackage

// ===== sv/lgs_cell.sv =====
// One link of the rotating grid chain: the current bit of one cell and the
// bit of the next generation that streams past it. Uses lgs_pkg.
module lgs_cell
   import lgs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         feed_cur,
   input  logic         feed_nxt,
   output logic         cur,
   output logic         nxt
);

   logic cur_ff, cur_in;
   logic nxt_ff, nxt_in;

   always_comb begin
      cur_in = cur_ff;
      nxt_in = nxt_ff;
      if (ctl.commit) begin
         cur_in = nxt_ff;
      end else if (ctl.shift) begin
         cur_in = feed_cur;
         nxt_in = feed_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_ff <= nxt_in;
   end

   assign cur = cur_ff;
   assign nxt = nxt_ff;

endmodule

// ===== sv/lgs_rule.sv =====
// Life rule for the cell at the head of the chain: counts the eight
// neighbour bits and gives the cell's next state. Uses lgs_pkg.
module lgs_rule
   import lgs_pkg::*;
(
   input  logic [NBR_W-1:0] nbr,
   input  logic             self_alive,
   output logic             next_alive
);

   logic [NBR_CNT_W-1:0] count;

   always_comb begin
      count = '0;
      for (int k = 0; k < NBR_W; k++) begin
         count = count + NBR_CNT_W'(nbr[k]);
      end
      next_alive = (count == BIRTH_COUNT) || ((count == KEEP_COUNT) && self_alive);
   end

endmodule

// ===== sv/life_generation_step_unit.sv =====
// Life grid of GRID_WIDTH x GRID_HEIGHT one-bit cells held in a rotating chain of cells.
// Every request (write, read or step) takes one full turn of the chain, and a
// step then loads the new generation; no new request is taken until the last
// one is answered. The chain shifts one cell past the head per cycle, where
// reads and writes meet their cell and the rule unit evaluates it. Reads and
// writes beyond the grid leave it untouched and answer 0; all other requests
// answer 0. The grid is all dead after reset. Depends on lgs_pkg, lgs_cell
// and lgs_rule.
module life_generation_step_unit
   import lgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic [IDX_W-1:0] req_cell_index,
   input  logic             req_cell_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_cell_state
);

   lgs_state_type state_ff, state_in;

   logic [1:0]       op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             val_ff, val_in;
   logic             read_ff, read_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_state_ff, rsp_state_in;

   cell_ctl_type ctl;
   logic         accept;
   logic         hit;
   logic         last;
   logic         rsp_free;
   logic         tail_cur;
   logic         tail_nxt;

   logic cur_w [LIFE_CELLS];
   logic nxt_w [LIFE_CELLS];

   logic [NBR_W-1:0] nbr;

   assign accept   = req_valid && !req_stall;
   assign hit      = (CMP_W'(pos_ff) == CMP_W'(idx_ff));
   assign last     = (pos_ff == CNT_W'(LIFE_CELLS - 1));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // head sits at position 0; neighbours are fixed taps modulo the grid size
   assign nbr = {cur_w[LIFE_CELLS-1],
                 cur_w[1],
                 cur_w[LIFE_CELLS-GRID_WIDTH],
                 cur_w[LIFE_CELLS-GRID_WIDTH-1],
                 cur_w[LIFE_CELLS-GRID_WIDTH+1],
                 cur_w[GRID_WIDTH],
                 cur_w[GRID_WIDTH-1],
                 cur_w[GRID_WIDTH+1]};

   lgs_rule u_rule (
      .nbr        (nbr),
      .self_alive (cur_w[0]),
      .next_alive (tail_nxt)
   );

   // head wraps to the tail; a write replaces its cell on the way round
   assign tail_cur = ((op_ff == REQ_WRITE) && hit) ? val_ff : cur_w[0];

   for (genvar p = 0; p < LIFE_CELLS; p++) begin : g_chain
      if (p == LIFE_CELLS - 1) begin : g_tail
         lgs_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .feed_cur (tail_cur),
            .feed_nxt (tail_nxt),
            .cur      (cur_w[p]),
            .nxt      (nxt_w[p])
         );
      end else begin : g_link
         lgs_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .feed_cur (cur_w[p+1]),
            .feed_nxt (nxt_w[p+1]),
            .cur      (cur_w[p]),
            .nxt      (nxt_w[p])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      read_ff      <= read_in;
      pos_ff       <= pos_in;
      rsp_state_ff <= rsp_state_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      read_in      = read_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_state_in = rsp_state_ff;
      ctl          = '0;
      req_stall    = (state_ff != ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_type;
               idx_in   = req_cell_index;
               val_in   = req_cell_value;
               read_in  = 1'b0;
               pos_in   = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            ctl.shift = 1'b1;
            pos_in    = pos_ff + CNT_W'(1);
            if ((op_ff == REQ_READ) && hit) begin
               read_in = cur_w[0];
            end
            if (last) begin
               state_in = (op_ff == REQ_STEP) ? ST_COMMIT : ST_FINISH;
            end
         end
         ST_COMMIT: begin
            ctl.commit = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = read_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_state = rsp_state_ff;

   a_sweep_starts_at_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) && ($past(state_ff) == ST_IDLE) |-> (pos_ff == '0))
      else $error("sweep did not start at the head of the chain");

   a_sweep_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) && ($past(state_ff) == ST_SWEEP)
      |-> (pos_ff == $past(pos_ff) + CNT_W'(1)))
      else $error("sweep position skipped or stalled");

   a_commit_only_on_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> (op_ff == REQ_STEP))
      else $error("generation loaded for a request that is not a step");

   a_read_bit_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) && read_ff |-> (op_ff == REQ_READ))
      else $error("read-back bit set for a request that is not a read");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for life_generation_step_unit: writes, reads, steps and the unused
// request code, with a behavioural grid predictor checked against every response word.
// Depends on lgs_pkg and the RTL of the unit.
module tb_top
   import lgs_pkg::*;
;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 20;
   localparam int WATCHDOG_LIMIT = 5 * (LIFE_CELLS + 3) + 2000;
   localparam int RANDOM_WORDS = 112;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] index;
      logic             value;
   } cell_req_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_type = REQ_WRITE;
   logic [IDX_W-1:0] req_cell_index = '0;
   logic             req_cell_value = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_cell_state;

   cell_req_type pending_words[$];
   bit           cell_state_expected[$];
   bit           life_grid[LIFE_CELLS];
   int           total_words = 0;
   int           words_sent = 0;
   int           words_answered = 0;
   int           mismatches = 0;
   int           idle_cycles = 0;

   life_generation_step_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_cell_index (req_cell_index),
      .req_cell_value (req_cell_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_state (rsp_cell_state)
   );

   always #4 clock = ~clock;

   // Gather the eight linear neighbours of each cell, wrapping modulo the grid size, and apply the life rule.
   function automatic void advance_life();
      bit next_grid[LIFE_CELLS];
      int live;
      int nb;
      for (int c = 0; c < LIFE_CELLS; c++) begin
         live = 0;
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
               if (dx != 0 || dy != 0) begin
                  nb = (LIFE_CELLS + c + dy * GRID_WIDTH + dx) % LIFE_CELLS;
                  live += life_grid[nb];
               end
            end
         end
         next_grid[c] = (live == int'(BIRTH_COUNT)) ||
                        (live == int'(KEEP_COUNT) && life_grid[c]);
      end
      life_grid = next_grid;
   endfunction

   function automatic bit predict_cell_state(cell_req_type r);
      bit answer;
      answer = 1'b0;
      case (r.op)
         REQ_WRITE: begin
            if (int'(r.index) < LIFE_CELLS) life_grid[r.index] = r.value;
         end
         REQ_READ: begin
            if (int'(r.index) < LIFE_CELLS) answer = life_grid[r.index];
         end
         REQ_STEP: advance_life();
         default: ;
      endcase
      return answer;
   endfunction

   function automatic void add_word(logic [1:0] op, int index, bit value);
      cell_req_type r;
      r.op    = op;
      r.index = IDX_W'(index);
      r.value = value;
      pending_words.push_back(r);
   endfunction

   function automatic int patch_cell(int base, int row, int col);
      return (base + row * GRID_WIDTH + col) % LIFE_CELLS;
   endfunction

   function automatic int traffic_phase();
      return (total_words == 0) ? 2 : (words_sent * 3) / total_words;
   endfunction

   // driver: hold the word while stalled, advance once it is taken
   always @(posedge clock) begin
      cell_req_type r;
      int idle_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            cell_state_expected.push_back(predict_cell_state(
               cell_req_type'{req_type, req_cell_index, req_cell_value}));
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            case (traffic_phase())
               0:       idle_pct = 10;
               1:       idle_pct = 87;
               default: idle_pct = 0;
            endcase
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               r = pending_words.pop_front();
               req_valid      <= 1'b1;
               req_type       <= r.op;
               req_cell_index <= r.index;
               req_cell_value <= r.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      bit expected_state;
      int stall_pct;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_answered++;
            if (cell_state_expected.size() == 0) begin
               $display("%0t: unexpected word, cell_state %0b", $time, rsp_cell_state);
               mismatches++;
            end else begin
               expected_state = cell_state_expected.pop_front();
               if (rsp_cell_state !== expected_state) begin
                  $display("%0t: cell_state mismatch, expected %0b actual %0b",
                           $time, expected_state, rsp_cell_state);
                  mismatches++;
               end
            end
         end
         case (traffic_phase())
            0:       stall_pct = 87;
            1:       stall_pct = 10;
            default: stall_pct = 0;
         endcase
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog: count cycles in which neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int base;
      int cnt;

      // single cells at corners and at cell 1, overwrite, unused code
      add_word(REQ_WRITE, 0, 1'b1);
      add_word(REQ_WRITE, GRID_WIDTH - 1, 1'b1);
      add_word(REQ_WRITE, 1, 1'b1);
      add_word(REQ_READ, 0, 1'b0);
      add_word(REQ_READ, LIFE_CELLS - 1, 1'b0);
      add_word(REQ_WRITE, LIFE_CELLS - 1, 1'b1);
      add_word(REQ_READ, LIFE_CELLS - 1, 1'b0);
      add_word(REQ_WRITE, LIFE_CELLS - 1, 1'b0);
      add_word(REQ_UNUSED, 0, 1'b1);
      add_word(REQ_READ, 0, 1'b1);
      // three cells W-1, 0 and 1: one step leaves cells 0 and W alive, the next clears them
      add_word(REQ_STEP, 0, 1'b0);
      add_word(REQ_READ, 0, 1'b0);
      add_word(REQ_READ, GRID_WIDTH, 1'b0);
      add_word(REQ_READ, LIFE_CELLS - GRID_WIDTH, 1'b0);
      add_word(REQ_STEP, 2 ** IDX_W - 1, 1'b1);
      add_word(REQ_READ, GRID_WIDTH - 1, 1'b0);
      add_word(REQ_READ, GRID_WIDTH, 1'b0);
      // glider placed at row 10, column 10 of the grid
      base = 10 * GRID_WIDTH + 10;
      add_word(REQ_WRITE, patch_cell(base, 0, 1), 1'b1);
      add_word(REQ_WRITE, patch_cell(base, 1, 2), 1'b1);
      add_word(REQ_WRITE, patch_cell(base, 2, 0), 1'b1);
      add_word(REQ_WRITE, patch_cell(base, 2, 1), 1'b1);
      add_word(REQ_WRITE, patch_cell(base, 2, 2), 1'b1);
      add_word(REQ_STEP, 0, 1'b0);
      add_word(REQ_STEP, 0, 1'b0);
      add_word(REQ_READ, patch_cell(base, 2, 1), 1'b0);
      add_word(REQ_READ, patch_cell(base, 3, 1), 1'b0);

      // mostly small random patches, stepped and read back; the rest noise
      cnt = 0;
      while (cnt < RANDOM_WORDS) begin
         if ($urandom_range(9) < 7) begin
            base = $urandom_range(LIFE_CELLS - 1);
            for (int k = 0; k < 6; k++) begin
               add_word(REQ_WRITE, patch_cell(base, $urandom_range(3), $urandom_range(3)),
                        $urandom_range(3) != 0);
            end
            for (int k = $urandom_range(1, 2); k > 0; k--) add_word(REQ_STEP, 0, 1'b0);
            for (int k = 0; k < 3; k++) begin
               add_word(REQ_READ, patch_cell(base, $urandom_range(4), $urandom_range(4)),
                        1'($urandom_range(1)));
            end
            cnt += 12;
         end else begin
            add_word(2'($urandom_range(3)), $urandom_range(2 ** IDX_W - 1),
                     1'($urandom_range(1)));
            cnt++;
         end
      end
      total_words = pending_words.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (words_answered < total_words);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && cell_state_expected.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== life_generation_step_unit.f =====
sv/lgs_pkg.sv
sv/lgs_cell.sv
sv/lgs_rule.sv
sv/life_generation_step_unit.sv
tb/tb_top.sv
